[hdl/decimal_text_to_fixed_point_defines.svh]
// Assertion macros shared by the decimal text to fixed point RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dtfp_pkg.sv]
// Types, constants and the power-of-ten table for the decimal text converter.
// No dependencies; used by dtfp_core, decimal_text_to_fixed_point and tb.
`timescale 1ns / 1ps

package dtfp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned FD_W    = 5;
    localparam int unsigned VALUE_W = 63;
    localparam int unsigned POW_W   = 64;

    localparam logic [FD_W-1:0]   MAX_FRACTION = 5'd18;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_POINT   = 8'h2E;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] fixed_value;
        logic               ok;
    } t_out_item;

    typedef struct packed {
        logic go;         // process the held request this cycle
        logic out_stall;  // result register is not being taken
    } t_core_ctl;

    // 10^k for k = 0..18; anything above reads as zero.
    function automatic logic [POW_W-1:0] pow10(input logic [FD_W-1:0] k);
        logic [POW_W-1:0] v;
        case (k)
            5'd0:    v = 64'd1;
            5'd1:    v = 64'd10;
            5'd2:    v = 64'd100;
            5'd3:    v = 64'd1000;
            5'd4:    v = 64'd10000;
            5'd5:    v = 64'd100000;
            5'd6:    v = 64'd1000000;
            5'd7:    v = 64'd10000000;
            5'd8:    v = 64'd100000000;
            5'd9:    v = 64'd1000000000;
            5'd10:   v = 64'd10000000000;
            5'd11:   v = 64'd100000000000;
            5'd12:   v = 64'd1000000000000;
            5'd13:   v = 64'd10000000000000;
            5'd14:   v = 64'd100000000000000;
            5'd15:   v = 64'd1000000000000000;
            5'd16:   v = 64'd10000000000000000;
            5'd17:   v = 64'd100000000000000000;
            5'd18:   v = 64'd1000000000000000000;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/dtfp_core.sv]
// Number state and result register of the decimal text converter.
// Depends on dtfp_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "decimal_text_to_fixed_point_defines.svh"

module dtfp_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dtfp_pkg::t_core_ctl              i_ctl,
    input  dtfp_pkg::t_in_item               i_item,
    input  logic [dtfp_pkg::FD_W-1:0]        i_fraction_digits,
    output logic                             o_res_valid,
    output dtfp_pkg::t_out_item              o_res
);
    import dtfp_pkg::*;

    localparam int unsigned SUM_W = VALUE_W + 5;

    // r_val holds the value already padded to the configured scale,
    // so the final request needs no padding loop.
    logic [VALUE_W-1:0] r_val,        n_val;
    logic [FD_W-1:0]    r_fc,         n_fc;
    logic               r_seen_point, n_seen_point;
    logic               r_seen_digit, n_seen_digit;
    logic               r_failed,     n_failed;
    logic               r_prev_point, n_prev_point;
    logic               r_out_valid;
    t_out_item          r_out,        n_out;

    logic               is_point;
    logic               is_digit;
    logic [3:0]         digit;
    logic [FD_W-1:0]    unit_idx;
    logic [SUM_W-1:0]   unit;
    logic [SUM_W-1:0]   scaled;
    logic [SUM_W-1:0]   base;
    logic [SUM_W-1:0]   sum;
    logic               ovf;
    logic               good;

    assign is_point = (i_item.char_code == CHAR_POINT);
    assign is_digit = (i_item.char_code >= CHAR_ZERO) && (i_item.char_code <= CHAR_NINE);
    assign digit    = i_item.char_code[3:0];

    // Place value of the new digit at the configured scale.
    assign unit_idx = r_seen_point ? (i_fraction_digits - r_fc - 5'd1) : i_fraction_digits;
    assign unit     = SUM_W'(pow10(unit_idx));
    assign scaled   = (digit[0] ? unit : '0)
                    + (digit[1] ? (unit << 1) : '0)
                    + (digit[2] ? (unit << 2) : '0)
                    + (digit[3] ? (unit << 3) : '0);
    assign base     = r_seen_point ? SUM_W'(r_val)
                    : (SUM_W'(r_val) << 3) + (SUM_W'(r_val) << 1);
    assign sum      = base + scaled;
    assign ovf      = |sum[SUM_W-1:VALUE_W];

    always_comb begin
        n_val        = r_val;
        n_fc         = r_fc;
        n_seen_point = r_seen_point;
        n_seen_digit = r_seen_digit;
        n_failed     = r_failed;
        n_prev_point = r_prev_point;
        if (!r_failed) begin
            if (is_point) begin
                if (r_seen_point || !r_seen_digit) begin
                    n_failed = 1'b1;
                end else begin
                    n_seen_point = 1'b1;
                    n_prev_point = 1'b1;
                end
            end else if (!is_digit) begin
                n_failed = 1'b1;
            end else begin
                n_seen_digit = 1'b1;
                n_prev_point = 1'b0;
                if (r_seen_point && (r_fc >= i_fraction_digits)) begin
                    // past the scale only zeros may follow; drop them
                    if (digit != 4'd0) begin
                        n_failed = 1'b1;
                    end
                end else if (ovf) begin
                    n_failed = 1'b1;
                end else begin
                    n_val = sum[VALUE_W-1:0];
                    if (r_seen_point) begin
                        n_fc = r_fc + 5'd1;
                    end
                end
            end
        end
    end

    assign good = !n_failed && n_seen_digit && !n_prev_point
               && (i_fraction_digits <= MAX_FRACTION);

    always_comb begin
        n_out.fixed_value = good ? n_val : '0;
        n_out.ok          = good;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val        <= '0;
            r_fc         <= '0;
            r_seen_point <= 1'b0;
            r_seen_digit <= 1'b0;
            r_failed     <= 1'b0;
            r_prev_point <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.go) begin
                if (i_item.last_char) begin
                    r_val        <= '0;
                    r_fc         <= '0;
                    r_seen_point <= 1'b0;
                    r_seen_digit <= 1'b0;
                    r_failed     <= 1'b0;
                    r_prev_point <= 1'b0;
                end else begin
                    r_val        <= n_val;
                    r_fc         <= n_fc;
                    r_seen_point <= n_seen_point;
                    r_seen_digit <= n_seen_digit;
                    r_failed     <= n_failed;
                    r_prev_point <= n_prev_point;
                end
            end
            if (i_ctl.go && i_item.last_char) begin
                r_out_valid <= 1'b1;
            end else if (!i_ctl.out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.go && i_item.last_char) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `DTFP_ASSERT_NEXT(a_clear_after_last, i_ctl.go && i_item.last_char, (r_val == '0) && (r_fc == '0) && !r_failed && !r_seen_digit && !r_seen_point, "number state not cleared after last character")
    `DTFP_ASSERT_NOW(a_fc_needs_point, !r_seen_point, r_fc == '0, "fraction count moved before a point")
    `DTFP_ASSERT_NOW(a_point_after_digit, r_prev_point, r_seen_point && r_seen_digit, "point flag without a digit and a point")
    `DTFP_ASSERT_NOW(a_bad_is_zero, r_out_valid && !r_out.ok, r_out.fixed_value == '0, "rejected result carries a nonzero value")

endmodule

[hdl/decimal_text_to_fixed_point.sv]
// Top level: ASCII decimal text to fixed point, one character per request.
// Depends on dtfp_pkg, dtfp_core and the shared assertion macro header.
//
// Input channel i_in_valid / o_in_stall carries one character and a last flag.
// Output channel o_out_valid / i_out_stall carries one result per number: the
// value scaled by 10^fraction_digits and an ok flag (value is zero when not ok).
// i_cfg_we / i_cfg_wdata set fraction_digits; write it only between numbers.
// Throughput: one character per cycle. Each character only needs a times-ten,
// one place-value add and compares against the already padded running value.
// The result is offered once the last character has been taken and held in the input
// register, then updated into the result register.
// Characters that are not last never wait on the output side. A last character
// waits in the input register while a previous result is stalled; the input
// then stalls, so at most one number's result is held back at a time.
// Reset (synchronous, active low) empties both registers, clears the number
// state and sets fraction_digits to zero.
`timescale 1ns / 1ps
`include "decimal_text_to_fixed_point_defines.svh"

module decimal_text_to_fixed_point (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  dtfp_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output dtfp_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_we,
    input  logic [dtfp_pkg::FD_W-1:0]    i_cfg_wdata
);
    import dtfp_pkg::*;

    logic [FD_W-1:0] r_fraction_digits;
    logic            r_in_valid;
    t_in_item        r_in;
    logic            res_valid;
    logic            out_free;
    logic            proc_go;
    logic            in_free;
    t_core_ctl       core_ctl;

    assign out_free   = !res_valid || !i_out_stall;
    assign proc_go    = r_in_valid && (!r_in.last_char || out_free);
    assign in_free    = !r_in_valid || proc_go;
    assign o_in_stall = !in_free;

    assign core_ctl = {proc_go, i_out_stall};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fraction_digits <= '0;
            r_in_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fraction_digits <= i_cfg_wdata;
            end
            if (in_free) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    // hold the request until the core takes it
    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    dtfp_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (core_ctl),
        .i_item            (r_in),
        .i_fraction_digits (r_fraction_digits),
        .o_res_valid       (res_valid),
        .o_res             (o_out_data)
    );

    assign o_out_valid = res_valid;

    `DTFP_ASSERT_NOW(a_stall_cause, o_in_stall,
        r_in_valid && r_in.last_char && res_valid && i_out_stall,
        "input stalled without a blocked result")
    `DTFP_ASSERT_NEXT(a_last_gives_result, proc_go && r_in.last_char, o_out_valid,
        "last character processed but no result")
    `DTFP_ASSERT_NEXT(a_plain_char_moves, r_in_valid && !r_in.last_char,
        !r_in_valid || !$stable(r_in) || $past(in_free),
        "plain character held in the input register")

endmodule

[sim/tb.sv]
// Testbench for decimal_text_to_fixed_point: feeds ASCII numbers one character per
// request and checks every result against a scoreboard that parses the same text.
// Depends on dtfp_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb;
    import dtfp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_CHARS  = 140;
    localparam int REPORT_CAP   = 40;

    localparam bit [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam bit [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Scoreboard: parses each accepted character and holds the expected results.
    class number_checker;
        localparam bit [63:0] VALUE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

        t_out_item        expected_values[$];
        bit [FD_W-1:0]    scale;
        bit [VALUE_W-1:0] acc;
        bit [FD_W-1:0]    frac_cnt;
        bit               seen_point;
        bit               seen_digit;
        bit               failed;
        bit               after_point;
        int               errors;
        int               good_count;
        int               bad_count;

        function new();
            scale      = '0;
            errors     = 0;
            good_count = 0;
            bad_count  = 0;
            clear_number();
        endfunction

        function void clear_number();
            acc         = '0;
            frac_cnt    = '0;
            seen_point  = 1'b0;
            seen_digit  = 1'b0;
            failed      = 1'b0;
            after_point = 1'b0;
        endfunction

        function void set_scale(input bit [FD_W-1:0] fd);
            scale = fd;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        function void parse_char(input bit [CHAR_W-1:0] c);
            bit [63:0] d;
            if (failed)
                return;
            if (c == CHAR_POINT) begin
                if (seen_point || !seen_digit)
                    failed = 1'b1;
                else begin
                    seen_point  = 1'b1;
                    after_point = 1'b1;
                end
                return;
            end
            if (c < CHAR_ZERO || c > CHAR_NINE) begin
                failed = 1'b1;
                return;
            end
            seen_digit  = 1'b1;
            after_point = 1'b0;
            // past the configured precision only zeros may follow
            if (seen_point && frac_cnt >= scale) begin
                if (c != CHAR_ZERO)
                    failed = 1'b1;
                return;
            end
            d = 64'(c - CHAR_ZERO);
            if ({1'b0, acc} > (VALUE_LIMIT - d) / 64'd10) begin
                failed = 1'b1;
                return;
            end
            acc = VALUE_W'({1'b0, acc} * 64'd10 + d);
            if (seen_point)
                frac_cnt = frac_cnt + 1'b1;
        endfunction

        function t_out_item close_number();
            t_out_item     r;
            bit [63:0]     v;
            bit [FD_W-1:0] n;
            bit            good;
            good = !failed && seen_digit && !after_point && (scale <= MAX_FRACTION);
            v    = {1'b0, acc};
            n    = frac_cnt;
            // pad up to the configured number of fraction digits
            while (good && n < scale) begin
                if (v > VALUE_LIMIT / 64'd10)
                    good = 1'b0;
                else begin
                    v = v * 64'd10;
                    n = n + 1'b1;
                end
            end
            r.fixed_value = good ? v[VALUE_W-1:0] : '0;
            r.ok          = good;
            if (good)
                good_count++;
            else
                bad_count++;
            clear_number();
            return r;
        endfunction

        function void note_request(input t_in_item it);
            parse_char(it.char_code);
            if (it.last_char)
                expected_values.insert(expected_values.size(), close_number());
        endfunction

        task report(input string msg);
            if (errors < REPORT_CAP)
                $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (expected_values.size() == 0) begin
                report($sformatf("result with no number pending: value %0d ok %0b",
                                 got.fixed_value, got.ok));
                return;
            end
            want = expected_values.pop_front();
            if (got.ok !== want.ok)
                report($sformatf("ok flag %0b, want %0b", got.ok, want.ok));
            if (got.fixed_value !== want.fixed_value)
                report($sformatf("value %0d, want %0d", got.fixed_value, want.fixed_value));
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [FD_W-1:0]  cfg_wdata = '0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_data;

    number_checker    sb;
    bit [CHAR_W-1:0]  text_q[$];
    int               chars_sent = 0;
    int               result_count = 0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    bit               calm = 1'b0;
    int               hold_asks = 0;
    int               hold_seen = 0;
    int               hold_left = 0;
    int               burst_left = 0;
    int               cycles = 0;

    bit [FD_W-1:0]    scale_plan[11] = '{5'd18, 5'd2, 5'd31, 5'd0, 5'd19, 5'd1,
                                         5'd9, 5'd17, 5'd5, 5'd18, 5'd3};

    decimal_text_to_fixed_point DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
            $display("tb failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left--;
            out_stall <= 1'b1;
        end else if (!calm && rst_n && $urandom_range(0, 99) < stall_pct) begin
            burst_left = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Outputs only move at the rising edge, so the falling edge sees the settled values.
    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            result_count++;
            sb.check_result(out_data);
        end
    end

    function automatic bit [CHAR_W-1:0] rand_digit();
        return CHAR_W'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // append one character to the text being built
    function automatic void add_char(input bit [CHAR_W-1:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic void load_string(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endfunction

    function automatic void build_text(input bit [FD_W-1:0] fd);
        string top_txt;
        int    mode;
        int    n_int;
        int    n_frac;
        int    k;
        top_txt = "9223372036854775807";
        text_q.delete();
        mode = $urandom_range(0, 99);
        // noise: a few arbitrary bytes
        if (mode >= 90) begin
            n_int = $urandom_range(1, 4);
            repeat (n_int) add_char(CHAR_W'($urandom_range(0, 255)));
            return;
        end
        // near the signed 64-bit limit, to hit digit and padding overflow
        if (mode >= 55 && mode < 75) begin
            k = $urandom_range(1, 19);
            for (int i = 0; i < k; i++)
                add_char(top_txt[i]);
            if ($urandom_range(0, 2) == 0)
                text_q[k-1] = rand_digit();
            if (k > 1 && $urandom_range(0, 1) == 1)
                text_q.insert($urandom_range(1, k - 1), CHAR_POINT);
            return;
        end
        n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : $urandom_range(1, 5);
        repeat (n_int) add_char(rand_digit());
        if ($urandom_range(0, 99) < 60) begin
            add_char(CHAR_POINT);
            n_frac = $urandom_range(1, (fd > MAX_FRACTION) ? 3 : fd + 2);
            for (int i = 0; i < n_frac; i++) begin
                if (i >= fd && $urandom_range(0, 3) != 0)
                    add_char(CHAR_ZERO);
                else
                    add_char(rand_digit());
            end
        end
        // break an otherwise well-formed number
        if (mode >= 75) begin
            case ($urandom_range(0, 4))
                0: text_q[$urandom_range(0, text_q.size() - 1)] =
                       CHAR_W'($urandom_range(0, 255));
                1: text_q.insert($urandom_range(0, text_q.size()), CHAR_POINT);
                2: text_q.push_front($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                3: text_q.push_front(CHAR_POINT);
                default: add_char(CHAR_POINT);
            endcase
        end
    endfunction

    task automatic send_char(input t_in_item it);
        bit taken;
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        chars_sent++;
        sb.note_request(it);
    endtask

    task automatic send_text();
        t_in_item it;
        for (int i = 0; i < text_q.size(); i++) begin
            it.char_code = text_q[i];
            it.last_char = (i == text_q.size() - 1);
            send_char(it);
        end
    endtask

    task automatic write_scale(input bit [FD_W-1:0] fd);
        cfg_we    <= 1'b1;
        cfg_wdata <= fd;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_scale(fd);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        string directed[8];
        int    phase_start;
        directed = '{"12.00", "3.5", "-3", ".5", "1.0.0", "7.", "0", "+12"};
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed numbers at the reset scale of zero
        idle_pct  = pick_pct();
        stall_pct = pick_pct();
        foreach (directed[i]) begin
            load_string(directed[i]);
            send_text();
        end
        text_q = '{8'hFF};
        send_text();
        wait_drained();

        for (int p = 0; p < $size(scale_plan); p++) begin
            calm      = (p == $size(scale_plan) - 1);
            idle_pct  = pick_pct();
            stall_pct = pick_pct();
            write_scale(scale_plan[p]);
            // long output hold-off so the block backs up into its input
            if (p == 1)
                hold_asks++;
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                build_text(scale_plan[p]);
                send_text();
            end
            wait_drained();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("Sent %0d characters over %0d scale settings including 0, 18 and 31.",
                 chars_sent, $size(scale_plan) + 1);
        $display("Checked %0d results: %0d valid numbers, %0d rejected.",
                 result_count, sb.good_count, sb.bad_count);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/dtfp_pkg.sv
hdl/dtfp_core.sv
hdl/decimal_text_to_fixed_point.sv
sim/tb.sv
